FILE: rtl/nfcrsp_pkg.sv
// Package: shared types, register indexes, status codes and frame constants.
package nfcrsp_pkg;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COMMAND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_TFI = 2'd2;

	localparam logic [DATA_W-1:0] RST_EXPECTED_COMMAND = 8'h00;
	localparam logic [DATA_W-1:0] RST_MAX_PAYLOAD = 8'd253;
	localparam logic [DATA_W-1:0] RST_DEVICE_TFI = 8'hD5;

	localparam logic [DATA_W-1:0] PREAMBLE_BYTE = 8'h00;
	localparam logic [DATA_W-1:0] START_CODE_1 = 8'h00;
	localparam logic [DATA_W-1:0] START_CODE_2 = 8'hFF;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] rx_byte;
		logic              frame_start;
	} in_item_t;

	typedef struct packed {
		logic              out_kind;
		logic [DATA_W-1:0] data_byte;
		logic [1:0]        status;
		logic [DATA_W-1:0] payload_count;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] expected_command;
		logic [DATA_W-1:0] max_payload;
		logic [DATA_W-1:0] device_tfi;
	} cfg_t;

	typedef struct packed {
		logic      has_result;
		out_item_t result;
	} step_t;

endpackage

FILE: rtl/nfcrsp_cfg_regs.sv
// Configuration register file written through a plain write port.
module nfcrsp_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [nfcrsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nfcrsp_pkg::DATA_W-1:0]    cfg_data,
	output nfcrsp_pkg::cfg_t                 cfg
);
	import nfcrsp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_command <= RST_EXPECTED_COMMAND;
			cfg_q.max_payload <= RST_MAX_PAYLOAD;
			cfg_q.device_tfi <= RST_DEVICE_TFI;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPECTED_COMMAND: cfg_q.expected_command <= cfg_data;
				REG_MAX_PAYLOAD:      cfg_q.max_payload <= cfg_data;
				REG_DEVICE_TFI:       cfg_q.device_tfi <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/nfcrsp_parser.sv
// Frame parser: phase state machine, length/sum tracking and per-byte result.
module nfcrsp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  nfcrsp_pkg::in_item_t item,
	input  nfcrsp_pkg::cfg_t     cfg,
	output nfcrsp_pkg::step_t    step
);
	import nfcrsp_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_SC1, PH_SC2, PH_LEN, PH_LCS, PH_TFI, PH_CMD,
		PH_DATA, PH_DCS, PH_POST, PH_DUMP, PH_SKIP1, PH_SKIP2
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [DATA_W-1:0] len_q, len_d;
	logic [DATA_W-1:0] sum_q, sum_d;
	logic [DATA_W-1:0] seen_q, seen_d;
	logic [DATA_W-1:0] b;
	logic [DATA_W-1:0] rsp;
	logic [DATA_W-1:0] len_m2;
	logic [DATA_W-1:0] seen_inc;
	step_t             st;

	assign b = item.rx_byte;
	assign rsp = cfg.expected_command + 8'd1;
	assign len_m2 = len_q - 8'd2;
	assign seen_inc = seen_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		sum_d = sum_q;
		seen_d = seen_q;
		st.has_result = 1'b0;
		st.result = '0;
		if (item.frame_start) begin
			len_d = '0;
			sum_d = '0;
			seen_d = '0;
			if (b != PREAMBLE_BYTE) begin
				st.has_result = 1'b1;
				phase_d = PH_IDLE;
			end else begin
				phase_d = PH_SC1;
			end
		end else begin
			unique case (phase_q)
				PH_SC1: begin
					if (b != START_CODE_1) begin
						st.has_result = 1'b1;
						phase_d = PH_IDLE;
					end else phase_d = PH_SC2;
				end
				PH_SC2: begin
					if (b != START_CODE_2) begin
						st.has_result = 1'b1;
						phase_d = PH_IDLE;
					end else phase_d = PH_LEN;
				end
				PH_LEN: begin
					len_d = b;
					phase_d = PH_LCS;
				end
				PH_LCS: begin
					if ((len_q + b) != 8'd0) begin
						st.has_result = 1'b1;
						phase_d = PH_IDLE;
					end else phase_d = PH_TFI;
				end
				PH_TFI: begin
					if (b != cfg.device_tfi) begin
						st.has_result = 1'b1;
						phase_d = PH_IDLE;
					end else phase_d = PH_CMD;
				end
				PH_CMD: begin
					if (b != rsp) begin
						st.has_result = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						len_d = len_m2;
						seen_d = '0;
						sum_d = cfg.device_tfi + rsp;
						if (len_m2 > cfg.max_payload) phase_d = PH_DUMP;
						else if (len_m2 == 8'd0) phase_d = PH_DCS;
						else phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					sum_d = sum_q + b;
					seen_d = seen_inc;
					if (seen_inc == len_q) phase_d = PH_DCS;
					st.has_result = 1'b1;
				end
				PH_DCS: begin
					if ((sum_q + b) != 8'd0) begin
						st.has_result = 1'b1;
						phase_d = PH_IDLE;
					end else phase_d = PH_POST;
				end
				PH_POST: begin
					st.has_result = 1'b1;
					phase_d = PH_IDLE;
				end
				PH_DUMP: begin
					seen_d = seen_inc;
					if (seen_inc == len_q) phase_d = PH_SKIP1;
				end
				PH_SKIP1: phase_d = PH_SKIP2;
				PH_SKIP2: begin
					st.has_result = 1'b1;
					phase_d = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end

		// result fields
		if (!item.frame_start && phase_q == PH_DATA) begin
			st.result.out_kind = KIND_DATA;
			st.result.data_byte = b;
		end else begin
			st.result.out_kind = KIND_FINAL;
			st.result.last = 1'b1;
			if (!item.frame_start && phase_q == PH_POST) begin
				st.result.status = ST_OK;
				st.result.payload_count = len_q;
			end else if (!item.frame_start && phase_q == PH_SKIP2) begin
				st.result.status = ST_NOSPACE;
			end else begin
				st.result.status = ST_INVALID;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q <= '0;
			sum_q <= '0;
			seen_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			len_q <= len_d;
			sum_q <= sum_d;
			seen_q <= seen_d;
		end
	end

	assign step = st;

endmodule

FILE: rtl/nfc_response_frame_parser_unit.sv
// Top level: input register, frame parser, config registers and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  in      | to block  | in_valid/in_stall  | in_item  (rx_byte, frame_start)
//  out     | from block| out_valid/out_stall| out_item (kind, byte, status, count, last)
//  cfg     | to block  | cfg_we             | cfg_index, cfg_data
//
// One byte per cycle sustained, unless a byte that makes a result meets a result
// held by out_stall; a byte's result goes from the input register through the parse
// logic into the result register, which drives the outputs.
// Reset clears the phase, length, sum and count state and loads the config defaults.
// A byte that makes no result moves through even while out_stall holds a result;
// a byte that makes one waits in the input register until the result register frees.
module nfc_response_frame_parser_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  nfcrsp_pkg::in_item_t             in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output nfcrsp_pkg::out_item_t            out_item,
	input  logic                             cfg_we,
	input  logic [nfcrsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nfcrsp_pkg::DATA_W-1:0]    cfg_data
);
	import nfcrsp_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_item_q;
	logic      out_valid_q;
	cfg_t      cfg;
	step_t     step;
	logic      advance;

	nfcrsp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nfcrsp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.step   (step)
	);

	assign advance = valid_s1 && (!step.has_result || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step.has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.has_result) out_item_q <= step.result;
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

FILE: rtl/nfcrsp_checker.sv
// Port-level checker for the response frame parser, with its bind.
module nfcrsp_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input nfcrsp_pkg::out_item_t out_item
);
	import nfcrsp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.last == out_item.out_kind)
		else $error("last does not match kind");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.out_kind == KIND_DATA |->
			out_item.status == ST_OK && out_item.payload_count == 8'd0)
		else $error("payload item carries status fields");

	a_final_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.out_kind == KIND_FINAL |->
			out_item.data_byte == 8'd0 &&
			(out_item.status == ST_OK || out_item.payload_count == 8'd0) &&
			(out_item.status == ST_OK || out_item.status == ST_INVALID ||
			 out_item.status == ST_NOSPACE))
		else $error("bad final item");

endmodule

bind nfc_response_frame_parser_unit nfcrsp_checker u_nfcrsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

FILE: tb/sv/nfc_response_frame_parser_unit_test.sv
// Testbench for the NFC response frame parser: framed byte stimulus, prediction and checking.
`timescale 1ns / 1ps

module nfc_response_frame_parser_unit_test;
	import nfcrsp_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 60;

	typedef enum logic [3:0] {
		PH_IDLE, PH_SC1, PH_SC2, PH_LEN, PH_LCS, PH_TFI, PH_CMD,
		PH_DATA, PH_DCS, PH_POST, PH_DUMP, PH_SKIP1, PH_SKIP2
	} parse_phase_e;

	typedef enum int {
		FR_GOOD, FR_EMPTY, FR_BAD_PREAMBLE, FR_BAD_SC1, FR_BAD_SC2, FR_BAD_LCS,
		FR_BAD_TFI, FR_BAD_CMD, FR_BAD_DCS, FR_RESTART, FR_NOISE, FR_OVERSIZE,
		FR_SHORT_LEN
	} frame_kind_e;

	class frame_checker;
		cfg_t live_cfg;
		parse_phase_e phase;
		logic [7:0] frame_len;
		logic [7:0] run_sum;
		logic [7:0] seen;
		out_item_t pending[$];
		int mismatches;

		function new();
			live_cfg = '{RST_EXPECTED_COMMAND, RST_MAX_PAYLOAD, RST_DEVICE_TFI};
			phase = PH_IDLE;
			frame_len = '0;
			run_sum = '0;
			seen = '0;
			mismatches = 0;
		endfunction

		function out_item_t final_item(logic [1:0] st, logic [7:0] count);
			out_item_t r;
			r = '0;
			r.out_kind = KIND_FINAL;
			r.status = st;
			r.payload_count = count;
			r.last = 1'b1;
			phase = PH_IDLE;
			return r;
		endfunction

		// Predict the result (if any) of one accepted byte.
		function void take_byte(in_item_t it);
			logic [7:0] b;
			logic [7:0] rsp;
			out_item_t r;
			bit has;
			b = it.rx_byte;
			has = 1'b0;
			r = '0;
			if (it.frame_start) begin
				frame_len = '0;
				run_sum = '0;
				seen = '0;
				if (b != PREAMBLE_BYTE) begin
					has = 1'b1;
					r = final_item(ST_INVALID, 8'd0);
				end else
					phase = PH_SC1;
			end else begin
				case (phase)
				PH_SC1: begin
					if (b != START_CODE_1) begin
						has = 1'b1;
						r = final_item(ST_INVALID, 8'd0);
					end else
						phase = PH_SC2;
				end
				PH_SC2: begin
					if (b != START_CODE_2) begin
						has = 1'b1;
						r = final_item(ST_INVALID, 8'd0);
					end else
						phase = PH_LEN;
				end
				PH_LEN: begin
					frame_len = b;
					phase = PH_LCS;
				end
				PH_LCS: begin
					if (8'(frame_len + b) != 8'd0) begin
						has = 1'b1;
						r = final_item(ST_INVALID, 8'd0);
					end else
						phase = PH_TFI;
				end
				PH_TFI: begin
					if (b != live_cfg.device_tfi) begin
						has = 1'b1;
						r = final_item(ST_INVALID, 8'd0);
					end else
						phase = PH_CMD;
				end
				PH_CMD: begin
					rsp = 8'(live_cfg.expected_command + 8'd1);
					if (b != rsp) begin
						has = 1'b1;
						r = final_item(ST_INVALID, 8'd0);
					end else begin
						frame_len = 8'(frame_len - 8'd2);
						seen = '0;
						run_sum = 8'(live_cfg.device_tfi + rsp);
						if (frame_len > live_cfg.max_payload)
							phase = PH_DUMP;
						else if (frame_len == 8'd0)
							phase = PH_DCS;
						else
							phase = PH_DATA;
					end
				end
				PH_DATA: begin
					run_sum = 8'(run_sum + b);
					seen = 8'(seen + 8'd1);
					if (seen == frame_len)
						phase = PH_DCS;
					has = 1'b1;
					r.out_kind = KIND_DATA;
					r.data_byte = b;
				end
				PH_DCS: begin
					if (8'(run_sum + b) != 8'd0) begin
						has = 1'b1;
						r = final_item(ST_INVALID, 8'd0);
					end else
						phase = PH_POST;
				end
				PH_POST: begin
					has = 1'b1;
					r = final_item(ST_OK, frame_len);
				end
				PH_DUMP: begin
					seen = 8'(seen + 8'd1);
					if (seen == frame_len)
						phase = PH_SKIP1;
				end
				PH_SKIP1: phase = PH_SKIP2;
				PH_SKIP2: begin
					has = 1'b1;
					r = final_item(ST_NOSPACE, 8'd0);
				end
				default: phase = PH_IDLE;
				endcase
			end
			if (has)
				pending.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				mismatches++;
				$error("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.out_kind !== want.out_kind) begin
				mismatches++;
				$error("out_kind expected %0h actual %0h", want.out_kind, got.out_kind);
			end
			if (got.data_byte !== want.data_byte) begin
				mismatches++;
				$error("data_byte expected %0h actual %0h", want.data_byte, got.data_byte);
			end
			if (got.status !== want.status) begin
				mismatches++;
				$error("status expected %0h actual %0h", want.status, got.status);
			end
			if (got.payload_count !== want.payload_count) begin
				mismatches++;
				$error("payload_count expected %0h actual %0h",
					want.payload_count, got.payload_count);
			end
			if (got.last !== want.last) begin
				mismatches++;
				$error("last expected %0h actual %0h", want.last, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	frame_checker frame_chk;
	cfg_t tb_cfg;
	bit steady;
	int hold_reqs;
	int items_sent;

	nfc_response_frame_parser_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("nfc_response_frame_parser_unit_test NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			frame_chk.take_byte(in_item);
		if (arst_n && out_valid && !out_stall)
			frame_chk.check_result(out_item);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		int served;
		served = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != served) begin
				served = hold_reqs;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= !steady && ($urandom_range(0, 99) < 12);
		end
	end

	task automatic send_byte(logic [7:0] b, logic s);
		while (!steady && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{rx_byte: b, frame_start: s};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_frame(frame_kind_e kind, int plen);
		logic [7:0] fb[$];
		logic [7:0] len;
		logic [7:0] rsp;
		logic [7:0] sum;
		logic [7:0] flip;
		logic [7:0] pb;
		int stop;
		if (kind == FR_NOISE) begin
			repeat ($urandom_range(1, 8))
				send_byte($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom),
					$urandom_range(0, 2) == 0);
			return;
		end
		flip = 8'($urandom_range(1, 255));
		len = 8'(plen + 2);
		rsp = 8'(tb_cfg.expected_command + 8'd1);
		sum = 8'(tb_cfg.device_tfi + rsp);
		fb = '{PREAMBLE_BYTE, START_CODE_1, START_CODE_2, len, 8'(8'd0 - len),
			tb_cfg.device_tfi, rsp};
		for (int i = 0; i < plen; i++) begin
			pb = 8'($urandom);
			sum = 8'(sum + pb);
			fb.push_back(pb);
		end
		fb.push_back(8'(8'd0 - sum));
		// postamble is not checked, so it is usually 00 but not always
		fb.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00);
		stop = fb.size();
		case (kind)
		FR_BAD_PREAMBLE: begin fb[0] ^= flip; stop = 1; end
		FR_BAD_SC1: begin fb[1] ^= flip; stop = 2; end
		FR_BAD_SC2: begin fb[2] ^= flip; stop = 3; end
		FR_BAD_LCS: begin fb[4] ^= flip; stop = 5; end
		FR_BAD_TFI: begin fb[5] ^= flip; stop = 6; end
		FR_BAD_CMD: begin fb[6] ^= flip; stop = 7; end
		FR_BAD_DCS: fb[plen + 7] ^= flip;
		FR_RESTART: stop = $urandom_range(1, fb.size() - 1);
		default: ;
		endcase
		for (int i = 0; i < stop; i++) begin
			send_byte(fb[i], i == 0);
			items_sent++;
		end
	endtask

	function automatic int payload_len(frame_kind_e kind);
		int top;
		int r;
		top = tb_cfg.max_payload;
		r = $urandom_range(0, 99);
		case (kind)
		FR_EMPTY: return 0;
		FR_SHORT_LEN: return 254 + $urandom_range(0, 1);
		FR_OVERSIZE: begin
			// above 253 every length fits, so only a plain frame is possible
			if (top > 253)
				return $urandom_range(1, 10);
			if (top == 253)
				return 254 + $urandom_range(0, 1);
			return $urandom_range(top + 1, (top + 16 > 253) ? 253 : top + 16);
		end
		default: ;
		endcase
		if (top == 0)
			return 0;
		if (r < 2)
			return top;
		if (r < 12)
			return $urandom_range(1, top < 48 ? top : 48);
		return $urandom_range(1, top < 10 ? top : 10);
	endfunction

	function automatic frame_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return FR_GOOD;
		if (r < 55) return FR_EMPTY;
		if (r < 73) return frame_kind_e'(FR_BAD_PREAMBLE + (r - 55) / 3);
		if (r < 78) return FR_BAD_DCS;
		if (r < 85) return FR_RESTART;
		if (r < 93) return FR_NOISE;
		if (r < 99) return FR_OVERSIZE;
		return FR_SHORT_LEN;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frame_chk.pending.size() != 0)
			@(posedge clk);
		repeat (6)
			@(posedge clk);
	endtask

	task automatic apply_settings(logic [7:0] cmd, logic [7:0] maxp, logic [7:0] tfi);
		cfg_we <= 1'b1;
		cfg_index <= REG_EXPECTED_COMMAND;
		cfg_data <= cmd;
		@(posedge clk);
		cfg_index <= REG_MAX_PAYLOAD;
		cfg_data <= maxp;
		@(posedge clk);
		cfg_index <= REG_DEVICE_TFI;
		cfg_data <= tfi;
		@(posedge clk);
		cfg_we <= 1'b0;
		tb_cfg = '{cmd, maxp, tfi};
		frame_chk.live_cfg = tb_cfg;
	endtask

	initial begin : main_seq
		int goal;
		frame_kind_e kind;
		frame_chk = new();
		tb_cfg = '{RST_EXPECTED_COMMAND, RST_MAX_PAYLOAD, RST_DEVICE_TFI};
		steady = 1'b0;
		hold_reqs = 0;
		items_sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray byte while idle, then each header check failing
		send_byte(8'h5A, 1'b0);
		for (int k = FR_BAD_PREAMBLE; k <= FR_BAD_CMD; k++)
			send_frame(frame_kind_e'(k), 1);
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
			0: apply_settings(8'hFF, 8'd253, 8'hD5);
			1: apply_settings(8'($urandom), 8'd255, 8'h00);
			2: apply_settings(8'h00, 8'd0, 8'hFF);
			3: apply_settings(8'($urandom), 8'($urandom_range(1, 40)), 8'($urandom));
			4: apply_settings(8'($urandom), 8'd254, 8'hD5);
			default: apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			steady = (p == 3);
			goal = items_sent + PHASE_ITEMS;
			if (p == 1) begin
				hold_reqs++;
				send_frame(FR_GOOD, 48);
				send_frame(FR_SHORT_LEN, payload_len(FR_SHORT_LEN));
			end
			for (int k = 0; k < FR_SHORT_LEN || items_sent < goal; k++) begin
				if (k < FR_SHORT_LEN)
					kind = frame_kind_e'(k);
				else
					kind = pick_kind();
				send_frame(kind, payload_len(kind));
			end
			drain();
		end

		if (frame_chk.mismatches == 0 && frame_chk.pending.size() == 0)
			$display("nfc_response_frame_parser_unit_test OK");
		else
			$display("nfc_response_frame_parser_unit_test NOT OK");
		$finish;
	end

endmodule

FILE: files.f
rtl/nfcrsp_pkg.sv
rtl/nfcrsp_cfg_regs.sv
rtl/nfcrsp_parser.sv
rtl/nfc_response_frame_parser_unit.sv
rtl/nfcrsp_checker.sv
tb/sv/nfc_response_frame_parser_unit_test.sv
